[hdl/buc_pkg.sv]
// Shared types and constants for the battery undervoltage cutoff block.
`default_nettype none
package buc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int ELAPSED_W  = 8;
  localparam int LEVEL_W    = 10;
  localparam int DELAY_W    = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam logic [DELAY_W-1:0] COUNT_MAX = {DELAY_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LEVEL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_DELAY_MS = 1'b1;

  localparam logic [LEVEL_W-1:0] CUTOFF_LEVEL_RST    = 10'd395;
  localparam logic [DELAY_W-1:0] CUTOFF_DELAY_MS_RST = 14'd4000;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  adc_sample;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic                relay_on;
    logic [LEVEL_W-1:0]  average_level;
    logic                below_cutoff;
    logic                timer_running;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [LEVEL_W-1:0]   average;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } avg_beat_t;

endpackage
`default_nettype wire

[hdl/buc_sample_cell.sv]
// One cell of the sample shift line: holds one sample and passes it on.
`default_nettype none
module buc_sample_cell
  import buc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire logic [SAMPLE_W-1:0] d_in,
  output logic      [SAMPLE_W-1:0] d_out
);

  logic [SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= d_in;
    end
  end

  assign d_out = sample_r;

endmodule
`default_nettype wire

[hdl/buc_avg.sv]
// Running total of the sample window and reciprocal-multiply average stage.
`default_nettype none
module buc_avg
  import buc_pkg::*;
#(
  parameter int WINDOW = 20
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  sample,
  input  wire logic [ELAPSED_W-1:0] elapsed_ms,
  input  wire logic [SAMPLE_W-1:0]  oldest,
  output logic                      shift_en,
  output avg_beat_t                 beat,
  input  wire logic                 beat_ready
);

  localparam int TOTAL_W = $clog2(WINDOW * (2**SAMPLE_W - 1) + 1);
  localparam int SH      = TOTAL_W + $clog2(WINDOW);
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = TOTAL_W + RECIP_W;
  localparam longint unsigned RECIP_VAL = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [TOTAL_W:0]     total_sum;
  logic                 s1_valid_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;
  logic                 s2_valid_r;
  logic [ELAPSED_W-1:0] s2_elapsed_r;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 s1_ready;
  logic                 s2_ready;

  assign s2_ready = !s2_valid_r || beat_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign shift_en = in_valid && s1_ready;

  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(sample) - (TOTAL_W+1)'(oldest);
  assign total_nxt = total_sum[TOTAL_W-1:0];
  assign prod_nxt  = PROD_W'(total_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (shift_en) begin
        total_r <= total_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      s1_elapsed_r <= elapsed_ms;
    end
    if (s2_ready && s1_valid_r) begin
      s2_elapsed_r <= s1_elapsed_r;
      prod_r       <= prod_nxt;
    end
  end

  assign beat.valid      = s2_valid_r;
  assign beat.average    = prod_r[SH +: LEVEL_W];
  assign beat.elapsed_ms = s2_elapsed_r;

endmodule
`default_nettype wire

[hdl/buc_cutoff.sv]
// Low-voltage latch, delay timer, relay state and result register.
`default_nettype none
module buc_cutoff
  import buc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire avg_beat_t          beat,
  output logic                    beat_ready,
  input  wire logic [LEVEL_W-1:0] cutoff_level,
  input  wire logic [DELAY_W-1:0] cutoff_delay_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data
);

  logic               low_latched_r,  low_latched_nxt;
  logic               delay_active_r, delay_active_nxt;
  logic [DELAY_W-1:0] delay_count_r,  delay_count_nxt;
  logic               relay_closed_r, relay_closed_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;
  logic [DELAY_W:0]   count_sum;
  logic               take;

  assign beat_ready = !out_valid_r || out_ready;
  assign take       = beat.valid && beat_ready;
  assign count_sum  = {1'b0, delay_count_r} + (DELAY_W+1)'(beat.elapsed_ms);

  always_comb begin
    low_latched_nxt  = low_latched_r;
    delay_active_nxt = delay_active_r;
    delay_count_nxt  = delay_count_r;
    relay_closed_nxt = relay_closed_r;
    if (delay_active_r) begin
      delay_count_nxt = count_sum[DELAY_W] ? COUNT_MAX : count_sum[DELAY_W-1:0];
    end
    if (cutoff_level > beat.average && !low_latched_r) begin
      low_latched_nxt  = 1'b1;
      delay_active_nxt = 1'b1;
      delay_count_nxt  = '0;
    end
    if (cutoff_level < beat.average) begin
      low_latched_nxt  = 1'b0;
      relay_closed_nxt = 1'b1;
      delay_active_nxt = 1'b0;
      delay_count_nxt  = '0;
    end
    if (delay_active_nxt && delay_count_nxt >= cutoff_delay_ms) begin
      delay_active_nxt = 1'b0;
      relay_closed_nxt = 1'b0;
    end
    out_data_nxt.relay_on      = relay_closed_nxt;
    out_data_nxt.average_level = beat.average;
    out_data_nxt.below_cutoff  = low_latched_nxt;
    out_data_nxt.timer_running = delay_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_latched_r  <= 1'b1;
      delay_active_r <= 1'b0;
      delay_count_r  <= '0;
      relay_closed_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        low_latched_r  <= low_latched_nxt;
        delay_active_r <= delay_active_nxt;
        delay_count_r  <= delay_count_nxt;
        relay_closed_r <= relay_closed_nxt;
      end
      if (beat_ready) begin
        out_valid_r <= beat.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hdl/battery_undervoltage_cutoff_top.sv]
// Battery undervoltage cutoff: moving-average filter, delay timer and relay control.
//
// Input beats carry one ADC sample and the milliseconds since the previous
// beat; each accepted beat yields exactly one result beat with the relay
// state, the truncated window average, the low latch and the timer flag.
// Both channels use valid/ready. A result passes the total, product and result
// registers after its input beat is accepted, and one beat per cycle is sustained
// while the receiver takes results: the sample shift line and running total, the
// reciprocal multiply and the cutoff state each take one register stage.
// A stalled receiver holds the result register; the stages behind it keep
// filling, so input is refused only once all three stages hold beats.
// The configuration port writes cutoff_level (index 0) or cutoff_delay_ms
// (index 1) on any edge with cfg_we high; write only while the block is idle.
// Synchronous reset clears the sample window and the total, sets the low
// latch, opens the relay, stops the timer and loads the default registers.
`default_nettype none
module battery_undervoltage_cutoff_top
  import buc_pkg::*;
#(
  parameter int WINDOW = 20
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LEVEL_W-1:0]  cutoff_level_r;
  logic [DELAY_W-1:0]  cutoff_delay_ms_r;
  logic [SAMPLE_W-1:0] tap [WINDOW+1];
  logic                shift_en;
  avg_beat_t           beat;
  logic                beat_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_level_r    <= CUTOFF_LEVEL_RST;
      cutoff_delay_ms_r <= CUTOFF_DELAY_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUTOFF_LEVEL:    cutoff_level_r    <= cfg_wdata[LEVEL_W-1:0];
        REG_CUTOFF_DELAY_MS: cutoff_delay_ms_r <= cfg_wdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tap[0] = in_data.adc_sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    buc_sample_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (tap[i]),
      .d_out    (tap[i+1])
    );
  end

  buc_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (in_data.adc_sample),
    .elapsed_ms (in_data.elapsed_ms),
    .oldest     (tap[WINDOW]),
    .shift_en   (shift_en),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  buc_cutoff u_cutoff (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat            (beat),
    .beat_ready      (beat_ready),
    .cutoff_level    (cutoff_level_r),
    .cutoff_delay_ms (cutoff_delay_ms_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule
`default_nettype wire

[tb/buc_cutoff_checker.sv]
// Checker for the undervoltage cutoff: predicts each result beat from accepted samples and compares.
module buc_cutoff_checker
  import buc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire out_item_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         results_owed
);

  localparam int RING_DEPTH = 20;

  logic [LEVEL_W-1:0]  level_reg;
  logic [DELAY_W-1:0]  delay_reg;
  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  int unsigned         slot;
  int unsigned         sum;
  int unsigned         held_ms;
  bit                  low_latch;
  bit                  timing;
  bit                  relay;
  out_item_t           owed_results[$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  function automatic out_item_t cutoff_step(input in_item_t beat);
    out_item_t   res;
    int unsigned avg;
    if (timing) begin
      held_ms += beat.elapsed_ms;
      if (held_ms > COUNT_MAX) held_ms = COUNT_MAX;
    end
    sum        = sum - ring[slot] + beat.adc_sample;
    ring[slot] = beat.adc_sample;
    slot       = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
    avg        = sum / RING_DEPTH;
    if (level_reg > avg && !low_latch) begin
      low_latch = 1'b1;
      timing    = 1'b1;
      held_ms   = 0;
    end
    if (level_reg < avg) begin
      low_latch = 1'b0;
      relay     = 1'b1;
      timing    = 1'b0;
      held_ms   = 0;
    end
    if (timing && held_ms >= delay_reg) begin
      timing = 1'b0;
      relay  = 1'b0;
    end
    res.relay_on      = relay;
    res.average_level = avg[LEVEL_W-1:0];
    res.below_cutoff  = low_latch;
    res.timer_running = timing;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      level_reg = CUTOFF_LEVEL_RST;
      delay_reg = CUTOFF_DELAY_MS_RST;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      slot      = 0;
      sum       = 0;
      held_ms   = 0;
      low_latch = 1'b1;
      timing    = 1'b0;
      relay     = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CUTOFF_LEVEL:    level_reg = cfg_wdata[LEVEL_W-1:0];
          REG_CUTOFF_DELAY_MS: delay_reg = cfg_wdata[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) owed_results.push_back(cutoff_step(in_data));
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing owed: relay %0b avg %0d low %0b timer %0b",
                     $time, out_data.relay_on, out_data.average_level,
                     out_data.below_cutoff, out_data.timer_running);
        end else begin
          want = owed_results.pop_front();
          if (out_data.relay_on !== want.relay_on ||
              out_data.average_level !== want.average_level ||
              out_data.below_cutoff !== want.below_cutoff ||
              out_data.timer_running !== want.timer_running) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch (exp/got) relay %0b/%0b avg %0d/%0d low %0b/%0b timer %0b/%0b",
                       $time, want.relay_on, out_data.relay_on,
                       want.average_level, out_data.average_level,
                       want.below_cutoff, out_data.below_cutoff,
                       want.timer_running, out_data.timer_running);
          end
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

[tb/battery_undervoltage_cutoff_top_tb.sv]
// Testbench top for the undervoltage cutoff: clock, reset, sample and register stimulus, verdict.
module battery_undervoltage_cutoff_top_tb;
  import buc_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int results_owed;
  int gap_odds   = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int beats      = 0;
  int settings   = 0;
  bit calm       = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  battery_undervoltage_cutoff_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  buc_cutoff_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic [ELAPSED_W-1:0] e);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{adc_sample: s, elapsed_ms: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats++;
  endtask

  task automatic set_thresholds(input logic [LEVEL_W-1:0] level, input logic [DELAY_W-1:0] delay_ms);
    logic [CFG_DATA_W-LEVEL_W-1:0] pad;
    pad = (CFG_DATA_W-LEVEL_W)'($urandom_range(0, 15));
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CUTOFF_LEVEL;
    cfg_wdata <= {pad, level};
    @(negedge clk);
    cfg_index <= REG_CUTOFF_DELAY_MS;
    cfg_wdata <= delay_ms;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int lvl, dly, sent, mode, len, tgt, smp, el_lo, el_hi;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_odds   = 4;
    stall_odds = 5;
    push_sample(10'd0, 8'd0);
    repeat (8) push_sample(10'd1023, 8'd255);
    set_thresholds(10'd409, 14'd0);
    push_sample(10'd0, 8'd17);
    set_thresholds(10'd410, 14'd0);
    push_sample(10'd0, 8'd0);
    set_thresholds(10'd408, 14'd16383);
    push_sample(10'd0, 8'd255);
    set_thresholds(10'd410, 14'd16383);
    repeat (4) push_sample(10'd0, 8'd255);
    push_sample(10'd1023, 8'd0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin lvl = 395;  dly = 4000;  end
        1: begin lvl = 1023; dly = 0;     end
        2: begin lvl = 0;    dly = 16383; end
        3: begin lvl = 900;  dly = 16383; end
        4: begin lvl = 512;  dly = 0;     end
        5: begin lvl = 250;  dly = 15000; end
        6: begin lvl = $urandom_range(0, 1023); dly = $urandom_range(0, 600);   end
        default: begin lvl = $urandom_range(0, 1023); dly = $urandom_range(0, 16383); end
      endcase
      if (ph == 7) calm = 1'b1;
      set_thresholds(LEVEL_W'(lvl), DELAY_W'(dly));
      sent = 0;
      while (sent < 165) begin
        mode = $urandom_range(0, 19);
        len  = $urandom_range(1, 80);
        case ($urandom_range(0, 2))
          0: begin el_lo = 0;   el_hi = 255; end
          1: begin el_lo = 180; el_hi = 255; end
          default: begin el_lo = 0; el_hi = 12; end
        endcase
        if (mode < 8)       tgt = lvl - int'($urandom_range(1, 80));
        else if (mode < 15) tgt = lvl + int'($urandom_range(1, 80));
        else                tgt = lvl;
        if (!calm) begin
          gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
          stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
        end
        for (int k = 0; k < len; k++) begin
          if (mode >= 17)      smp = $urandom_range(0, 1023);
          else if (mode >= 15) smp = tgt;
          else                 smp = tgt + int'($urandom_range(0, 40)) - 20;
          if (smp < 0)    smp = 0;
          if (smp > 1023) smp = 1023;
          push_sample(SAMPLE_W'(smp), ELAPSED_W'($urandom_range(el_lo, el_hi)));
        end
        sent += len;
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d sample beats across %0d level and delay settings,", beats, settings);
    $display("with sender gaps and receiver stalls except in the final stretch");
    if (mismatches == 0 && results_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule

[battery_undervoltage_cutoff_top.f]
hdl/buc_pkg.sv
hdl/buc_sample_cell.sv
hdl/buc_avg.sv
hdl/buc_cutoff.sv
hdl/battery_undervoltage_cutoff_top.sv
tb/buc_cutoff_checker.sv
tb/battery_undervoltage_cutoff_top_tb.sv
